// ----- rtl/rmq_pkg.sv -----
// Shared types and constants of the rotation-matrix-to-quaternion core.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rmq_pkg;

    // epsilon threshold register
    localparam int               EPS_W     = 15;
    localparam logic [EPS_W-1:0] EPS_RESET = 15'd16;

    // formula selected for an item
    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_XMAJ  = 2'd1,
        CASE_YMAJ  = 2'd2,
        CASE_ZMAJ  = 2'd3
    } t_case;

endpackage

// ----- rtl/rmq_if.sv -----
// Valid/ready channel interfaces: matrix in, quaternion out, config write.
// Depends on rmq_pkg for the epsilon register width.
`timescale 1ns / 1ps

interface rmq_mat_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00, m01, m02;
    logic signed [DATA_WIDTH-1:0] m10, m11, m12;
    logic signed [DATA_WIDTH-1:0] m20, m21, m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface rmq_quat_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_x, quat_y, quat_z, quat_w;
    logic [1:0]                   case_taken;
    logic                         saturated;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, case_taken, saturated,
                    input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, case_taken, saturated,
                    output ready);
endinterface

interface rmq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rmq_pkg::EPS_W-1:0]   epsilon_threshold;

    modport source (output valid, epsilon_threshold, input ready);
    modport sink   (input valid, epsilon_threshold, output ready);
endinterface

// ----- rtl/rmq_sqrt_cell.sv -----
// One cell of the square-root chain: decides root bit B and passes on.
// No dependencies.
`timescale 1ns / 1ps

module rmq_sqrt_cell #(
    parameter int NW = 32,
    parameter int SW = 16,
    parameter int B  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_rem,
    input  logic [SW-1:0] i_root,
    output logic [NW-1:0] o_rem,
    output logic [SW-1:0] o_root
);
    localparam int TW = NW + 2;

    logic [NW-1:0] r_rem,  n_rem;
    logic [SW-1:0] r_root, n_root;
    logic [TW-1:0] w_term, w_diff;
    logic          w_take;

    // rem = n - root^2; (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign w_term = (TW'(i_root) << (B + 1)) + (TW'(1) << (2 * B));
    assign w_diff = TW'(i_rem) - w_term;
    assign w_take = TW'(i_rem) >= w_term;

    always_comb begin
        n_rem  = w_take ? w_diff[NW-1:0] : i_rem;
        n_root = w_take ? (i_root | (SW'(1) << B)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

// ----- rtl/rmq_div_cell.sv -----
// One cell of the restoring divider chain: produces quotient bit J.
// No dependencies.
`timescale 1ns / 1ps

module rmq_div_cell #(
    parameter int DW = 32,
    parameter int VW = 17,
    parameter int J  = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_den,
    input  logic [VW-1:0] i_rem,
    input  logic [DW-1:0] i_quo,
    output logic [DW-1:0] o_dvd,
    output logic [VW-1:0] o_rem,
    output logic [DW-1:0] o_quo
);
    logic [DW-1:0] r_dvd, r_quo, n_quo;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW:0]   w_sh, w_sub;
    logic          w_take;

    assign w_sh   = {i_rem, i_dvd[J]};
    assign w_take = w_sh >= {1'b0, i_den};
    assign w_sub  = w_sh - {1'b0, i_den};

    always_comb begin
        n_rem = w_take ? w_sub[VW-1:0] : w_sh[VW-1:0];
        n_quo = w_take ? (i_quo | (DW'(1) << J)) : i_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd <= i_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_dvd = r_dvd;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
endmodule

// ----- rtl/rotation_matrix_to_quaternion_core.sv -----
// Rotation matrix (Q format) to quaternion, Shepperd's method, fully pipelined.
// Depends on rmq_pkg, rmq_if, rmq_sqrt_cell, rmq_div_cell.
//
// Usage:
//   i_mat  : matrix beats (m00..m22), valid/ready, one beat per cycle unless stalled.
//   o_quat : quaternion beats (x, y, z, w, case_taken, saturated), valid/ready.
//   i_cfg  : epsilon_threshold write, always ready, write only while idle.
// Stages: front register, SW square-root cells, DW divider cells and the
//   output register, with RW = max(DATA_WIDTH, FRAC_BITS) + 2, SW =
//   ceil((RW + FRAC_BITS) / 2) root bits (one sqrt cell each) and DW =
//   max(DATA_WIDTH + 1 + FRAC_BITS, SW) + 1 quotient bits (one divider cell each).
// Throughput: one beat per cycle unless stalled. Every cell of the chains
//   advances each cycle unless stalled; the three divisions run in parallel lanes.
// Stall: while the output register holds an untaken beat, the whole chain
//   freezes and i_mat.ready is low; it is high again once o_quat is taken.
// Reset (i_rst_n, synchronous): pipeline emptied, epsilon back to 16.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rmq_cfg_if.sink           i_cfg,
    rmq_mat_if.sink           i_mat,
    rmq_quat_if.source        o_quat
);
    import rmq_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int RW = ((W > F) ? W : F) + 2;
    localparam int NW = RW + F;
    localparam int SW = (NW + 1) / 2;
    localparam int VW = SW + 1;
    localparam int MW = W + 1;
    localparam int DW = (((MW + F) > SW) ? (MW + F) : SW) + 1;

    localparam logic signed [RW:0] ONE_R   = (RW + 1)'(1) << F;
    localparam logic signed [RW:0] ONE_LSB = (RW + 1)'(1);
    localparam logic [DW-1:0] LIM_POS = DW'((64'(1) << (W - 1)) - 64'(1));
    localparam logic [DW-1:0] LIM_NEG = DW'(64'(1) << (W - 1));
    localparam logic [W-1:0]  QMAX    = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  QMIN    = {1'b1, {(W - 1){1'b0}}};

    typedef struct packed {
        t_case              cs;
        logic [2:0]         neg;
        logic [2:0][MW-1:0] mag;
    } t_front;

    typedef struct packed {
        t_case         cs;
        logic [2:0]    neg;
        logic [SW-1:0] half;
        logic [VW-1:0] den;
    } t_mid;

    logic             w_en;
    logic [EPS_W-1:0] r_eps;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg.valid) begin
            r_eps <= i_cfg.epsilon_threshold;
        end
    end

    // ---------------- front: branch, radicand, numerators ----------------
    logic signed [RW:0] w_m00, w_m11, w_m22, w_eps, w_rt, w_r;
    logic signed [MW-1:0] w_n0, w_n1, w_n2;
    logic signed [MW-1:0] w_d12_21, w_d20_02, w_d01_10, w_s10_01, w_s20_02, w_s21_12;
    t_front           n_fr, r_fr;
    logic [RW-1:0]    n_fr_rad, r_fr_rad;
    logic             r_fr_vld;

    assign w_m00 = (RW + 1)'(i_mat.m00);
    assign w_m11 = (RW + 1)'(i_mat.m11);
    assign w_m22 = (RW + 1)'(i_mat.m22);
    assign w_eps = $signed((RW + 1)'(r_eps));
    assign w_rt  = w_m00 + w_m11 + w_m22 + ONE_R;

    assign w_d12_21 = MW'(i_mat.m12) - MW'(i_mat.m21);
    assign w_d20_02 = MW'(i_mat.m20) - MW'(i_mat.m02);
    assign w_d01_10 = MW'(i_mat.m01) - MW'(i_mat.m10);
    assign w_s10_01 = MW'(i_mat.m10) + MW'(i_mat.m01);
    assign w_s20_02 = MW'(i_mat.m20) + MW'(i_mat.m02);
    assign w_s21_12 = MW'(i_mat.m21) + MW'(i_mat.m12);

    always_comb begin
        n_fr = '0;
        priority if (w_rt > w_eps) begin
            n_fr.cs = CASE_TRACE;
            w_r  = w_rt;
            w_n0 = w_d12_21; w_n1 = w_d20_02; w_n2 = w_d01_10;
        end else if (i_mat.m00 > i_mat.m11 && i_mat.m00 > i_mat.m22) begin
            n_fr.cs = CASE_XMAJ;
            w_r  = ONE_R + w_m00 - w_m11 - w_m22;
            w_n0 = w_s10_01; w_n1 = w_s20_02; w_n2 = w_d12_21;
        end else if (i_mat.m11 > i_mat.m22) begin
            n_fr.cs = CASE_YMAJ;
            w_r  = ONE_R + w_m11 - w_m00 - w_m22;
            w_n0 = w_s10_01; w_n1 = w_s21_12; w_n2 = w_d20_02;
        end else begin
            n_fr.cs = CASE_ZMAJ;
            w_r  = ONE_R + w_m22 - w_m00 - w_m11;
            w_n0 = w_s20_02; w_n1 = w_s21_12; w_n2 = w_d01_10;
        end
        // non-rotation input: keep the divisor nonzero
        n_fr_rad   = (w_r < ONE_LSB) ? RW'(1) : w_r[RW-1:0];
        n_fr.neg   = {w_n2[MW-1], w_n1[MW-1], w_n0[MW-1]};
        n_fr.mag[0] = w_n0[MW-1] ? MW'(-w_n0) : MW'(w_n0);
        n_fr.mag[1] = w_n1[MW-1] ? MW'(-w_n1) : MW'(w_n1);
        n_fr.mag[2] = w_n2[MW-1] ? MW'(-w_n2) : MW'(w_n2);
    end

    assign i_mat.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_vld <= 1'b0;
        end else if (w_en) begin
            r_fr_vld <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fr     <= n_fr;
            r_fr_rad <= n_fr_rad;
        end
    end

    // ---------------- square-root chain ----------------
    logic [NW-1:0] w_sq_rem  [SW];
    logic [SW-1:0] w_sq_root [SW];
    t_front        r_sq_sb   [SW];
    logic [SW-1:0] r_sq_vld;

    genvar k;
    generate
        for (k = 0; k < SW; k++) begin : g_sqrt
            logic [NW-1:0] w_rem_in;
            logic [SW-1:0] w_root_in;
            if (k == 0) begin : g_first
                assign w_rem_in  = {r_fr_rad, {F{1'b0}}};
                assign w_root_in = '0;
            end else begin : g_next
                assign w_rem_in  = w_sq_rem[k-1];
                assign w_root_in = w_sq_root[k-1];
            end
            rmq_sqrt_cell #(.NW(NW), .SW(SW), .B(SW - 1 - k)) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_rem  (w_rem_in),
                .i_root (w_root_in),
                .o_rem  (w_sq_rem[k]),
                .o_root (w_sq_root[k])
            );
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_sb[k] <= (k == 0) ? r_fr : r_sq_sb[(k == 0) ? 0 : k - 1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
        end else if (w_en) begin
            r_sq_vld <= {r_sq_vld[SW-2:0], r_fr_vld};
        end
    end

    // ---------------- divider setup ----------------
    logic [SW-1:0] w_s;
    logic [SW:0]   w_hsum;
    t_mid          w_mid;
    logic [DW-1:0] w_dvd_in [3];

    assign w_s    = w_sq_root[SW-1];
    assign w_hsum = (SW + 1)'(w_s) + (SW + 1)'(1);

    always_comb begin
        w_mid.cs   = r_sq_sb[SW-1].cs;
        w_mid.neg  = r_sq_sb[SW-1].neg;
        w_mid.half = w_hsum[SW:1];
        w_mid.den  = {w_s, 1'b0};
        for (int l = 0; l < 3; l++) begin
            // +S rounds the quotient by 2S to nearest
            w_dvd_in[l] = (DW'(r_sq_sb[SW-1].mag[l]) << F) + DW'(w_s);
        end
    end

    // ---------------- divider chains, three lanes ----------------
    logic [DW-1:0] w_dv_dvd [3][DW];
    logic [VW-1:0] w_dv_rem [3][DW];
    logic [DW-1:0] w_dv_quo [3][DW];
    t_mid          r_dv_sb  [DW];
    logic [DW-1:0] r_dv_vld;

    genvar l, j;
    generate
        for (j = 0; j < DW; j++) begin : g_dsb
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_sb[j] <= (j == 0) ? w_mid : r_dv_sb[(j == 0) ? 0 : j - 1];
                end
            end
        end
        for (l = 0; l < 3; l++) begin : g_lane
            for (j = 0; j < DW; j++) begin : g_div
                logic [DW-1:0] w_dvd_c, w_quo_c;
                logic [VW-1:0] w_rem_c, w_den_c;
                if (j == 0) begin : g_first
                    assign w_dvd_c = w_dvd_in[l];
                    assign w_quo_c = '0;
                    assign w_rem_c = '0;
                    assign w_den_c = w_mid.den;
                end else begin : g_next
                    assign w_dvd_c = w_dv_dvd[l][j-1];
                    assign w_quo_c = w_dv_quo[l][j-1];
                    assign w_rem_c = w_dv_rem[l][j-1];
                    assign w_den_c = r_dv_sb[j-1].den;
                end
                rmq_div_cell #(.DW(DW), .VW(VW), .J(DW - 1 - j)) u_cell (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_dvd (w_dvd_c),
                    .i_den (w_den_c),
                    .i_rem (w_rem_c),
                    .i_quo (w_quo_c),
                    .o_dvd (w_dv_dvd[l][j]),
                    .o_rem (w_dv_rem[l][j]),
                    .o_quo (w_dv_quo[l][j])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
        end else if (w_en) begin
            r_dv_vld <= {r_dv_vld[DW-2:0], r_sq_vld[SW-1]};
        end
    end

    // ---------------- sign, clip, slot mapping ----------------
    t_mid          w_end;
    logic [W-1:0]  w_lv [3];
    logic [2:0]    w_ls;
    logic [W-1:0]  w_hv;
    logic          w_hs;
    logic [W-1:0]  n_x, n_y, n_z, n_w;
    logic          n_sat;

    assign w_end = r_dv_sb[DW-1];

    always_comb begin
        logic [DW-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = w_dv_quo[i][DW-1];
            if (w_end.neg[i]) begin
                w_ls[i] = q > LIM_NEG;
                w_lv[i] = w_ls[i] ? QMIN : (W'(0) - q[W-1:0]);
            end else begin
                w_ls[i] = q > LIM_POS;
                w_lv[i] = w_ls[i] ? QMAX : q[W-1:0];
            end
        end
        w_hs = DW'(w_end.half) > LIM_POS;
        w_hv = w_hs ? QMAX : W'(w_end.half);
        n_sat = w_hs | (|w_ls);
        unique case (w_end.cs)
            CASE_TRACE: begin
                n_x = w_lv[0]; n_y = w_lv[1]; n_z = w_lv[2]; n_w = w_hv;
            end
            CASE_XMAJ: begin
                n_x = w_hv; n_y = w_lv[0]; n_z = w_lv[1]; n_w = w_lv[2];
            end
            CASE_YMAJ: begin
                n_x = w_lv[0]; n_y = w_hv; n_z = w_lv[1]; n_w = w_lv[2];
            end
            default: begin
                n_x = w_lv[0]; n_y = w_lv[1]; n_z = w_hv; n_w = w_lv[2];
            end
        endcase
    end

    // ---------------- output register ----------------
    logic         r_out_vld, r_out_sat;
    t_case        r_out_cs;
    logic [W-1:0] r_out_x, r_out_y, r_out_z, r_out_w;

    assign w_en = !r_out_vld || o_quat.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_dv_vld[DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x   <= n_x;
            r_out_y   <= n_y;
            r_out_z   <= n_z;
            r_out_w   <= n_w;
            r_out_cs  <= w_end.cs;
            r_out_sat <= n_sat;
        end
    end

    assign o_quat.valid      = r_out_vld;
    assign o_quat.quat_x     = r_out_x;
    assign o_quat.quat_y     = r_out_y;
    assign o_quat.quat_z     = r_out_z;
    assign o_quat.quat_w     = r_out_w;
    assign o_quat.case_taken = r_out_cs;
    assign o_quat.saturated  = r_out_sat;

`ifndef SYNTHESIS
    // the major component comes from a square root and is never negative
    a_major_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |->
            (r_out_cs == CASE_TRACE && !r_out_w[W-1]) ||
            (r_out_cs == CASE_XMAJ  && !r_out_x[W-1]) ||
            (r_out_cs == CASE_YMAJ  && !r_out_y[W-1]) ||
            (r_out_cs == CASE_ZMAJ  && !r_out_z[W-1]))
        else $error("major quaternion component negative");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_sat |->
            r_out_x == QMAX || r_out_x == QMIN || r_out_y == QMAX || r_out_y == QMIN ||
            r_out_z == QMAX || r_out_z == QMIN || r_out_w == QMAX || r_out_w == QMIN)
        else $error("saturated flag without a clipped component");

    a_front_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_en) |-> r_fr_vld == $past(i_mat.valid))
        else $error("front stage valid lost an accepted beat");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(w_en) |-> $stable(r_dv_vld) && $stable(r_sq_vld))
        else $error("pipeline moved while the output was stalled");
`endif
endmodule
